// ===== hdl/clipped_alpha_glyph_blit_assert.svh =====
// Assertion macros shared by the glyph blitter RTL.
`ifndef CLIPPED_ALPHA_GLYPH_BLIT_ASSERT_SVH
`define CLIPPED_ALPHA_GLYPH_BLIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CAGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CAGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cagb_pkg.sv =====
// Shared types, constants and helpers for the glyph blitter.
`default_nettype none

package cagb_pkg;

    localparam int MAX_GLYPH_SIZE = 64;
    localparam int COUNT_W        = $clog2(MAX_GLYPH_SIZE);
    localparam int SIZE_W         = 7;
    localparam int COORD_W        = 13;
    localparam int COLOR_W        = 24;
    localparam int ADDR_W         = 24;
    localparam int ALPHA_W        = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'hFF;

    localparam logic [COORD_W-1:0] SCREEN_W_RESET = 13'd640;
    localparam logic [COORD_W-1:0] SCREEN_H_RESET = 13'd480;
    localparam logic [COLOR_W-1:0] FORE_RESET     = 24'hFFFFFF;
    localparam logic [COLOR_W-1:0] BACK_RESET     = 24'h000000;
    localparam logic [SIZE_W-1:0]  SIZE_RESET     = 7'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GLYPH_LEFT    = 3'd0,
        REG_GLYPH_TOP     = 3'd1,
        REG_GLYPH_WIDTH   = 3'd2,
        REG_GLYPH_HEIGHT  = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_FORE_COLOR    = 3'd6,
        REG_BACK_COLOR    = 3'd7
    } cfg_reg_t;

    // Zero counts as one, anything above the maximum saturates.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_GLYPH_SIZE))
            r = SIZE_W'(MAX_GLYPH_SIZE);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cagb_blend.sv =====
// Per-channel alpha blend of foreground over background for one RGB pixel.
`default_nettype none

module cagb_blend (
    input  wire logic [cagb_pkg::ALPHA_W-1:0] alpha,
    input  wire logic [cagb_pkg::COLOR_W-1:0] fore,
    input  wire logic [cagb_pkg::COLOR_W-1:0] back,
    output logic      [cagb_pkg::COLOR_W-1:0] blended
);

    localparam int CHANNELS = cagb_pkg::COLOR_W / cagb_pkg::ALPHA_W;
    localparam int CH_W     = cagb_pkg::ALPHA_W;

    logic [CH_W-1:0] inv_alpha;

    assign inv_alpha = cagb_pkg::ALPHA_MAX - alpha;

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic [2*CH_W-1:0] fg_term;
        logic [2*CH_W-1:0] bg_term;
        logic [2*CH_W-1:0] sum;

        // Largest sum is 255*255, so 16 bits never overflow.
        assign fg_term = fore[c*CH_W +: CH_W] * alpha;
        assign bg_term = back[c*CH_W +: CH_W] * inv_alpha;
        assign sum     = fg_term + bg_term;
        assign blended[c*CH_W +: CH_W] = sum[2*CH_W-1:CH_W];
    end

endmodule

`default_nettype wire

// ===== hdl/clipped_alpha_glyph_blit.sv =====
// Top level of the clipped alpha glyph blitter.
// Coverage bytes arrive one per transfer in raster order over the glyph
// rectangle placed at (glyph_left, glyph_top). Each transfer in gives exactly
// one transfer out carrying a write flag (tuser), the linear framebuffer
// address row*screen_width+column and the blended colour, each channel
// (bg*(255-a)+fg*a)>>8. Pixels outside the framebuffer come out with the flag
// low and zero address and colour. tlast marks the final pixel of the glyph,
// after which the scan returns to the top-left corner. Throughput is one pixel
// per clock while m_tready is high; each result passes through the position
// stage and then the address-multiply/blend stage that follows it. Width
// and height of 0 act as 1, above 64 saturate to 64. Register writes leave the
// scan position alone and must be made while no pixel is in flight.
`default_nettype none

module clipped_alpha_glyph_blit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [cagb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cagb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // coverage stream in
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] coverage
    // pixel stream out
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [23:0] pixel_address, [47:24] pixel_color
    output logic             m_tuser,   // write_enable
    output logic             m_tlast    // last_pixel
);

    localparam int CW = cagb_pkg::COUNT_W;
    localparam int SW = cagb_pkg::SIZE_W;
    localparam int XW = cagb_pkg::COORD_W;

    // configuration registers
    logic signed [XW-1:0]             glyph_left_reg;
    logic signed [XW-1:0]             glyph_top_reg;
    logic [SW-1:0]                    glyph_width_reg;
    logic [SW-1:0]                    glyph_height_reg;
    logic [XW-1:0]                    screen_width_reg;
    logic [XW-1:0]                    screen_height_reg;
    logic [cagb_pkg::COLOR_W-1:0]     fore_color_reg;
    logic [cagb_pkg::COLOR_W-1:0]     back_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_left_reg    <= '0;
            glyph_top_reg     <= '0;
            glyph_width_reg   <= cagb_pkg::SIZE_RESET;
            glyph_height_reg  <= cagb_pkg::SIZE_RESET;
            screen_width_reg  <= cagb_pkg::SCREEN_W_RESET;
            screen_height_reg <= cagb_pkg::SCREEN_H_RESET;
            fore_color_reg    <= cagb_pkg::FORE_RESET;
            back_color_reg    <= cagb_pkg::BACK_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cagb_pkg::cfg_reg_t'(cfg_index))
                cagb_pkg::REG_GLYPH_LEFT:    glyph_left_reg    <= cfg_data[XW-1:0];
                cagb_pkg::REG_GLYPH_TOP:     glyph_top_reg     <= cfg_data[XW-1:0];
                cagb_pkg::REG_GLYPH_WIDTH:   glyph_width_reg   <= cfg_data[SW-1:0];
                cagb_pkg::REG_GLYPH_HEIGHT:  glyph_height_reg  <= cfg_data[SW-1:0];
                cagb_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[XW-1:0];
                cagb_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[XW-1:0];
                cagb_pkg::REG_FORE_COLOR:    fore_color_reg    <= cfg_data;
                cagb_pkg::REG_BACK_COLOR:    back_color_reg    <= cfg_data;
            endcase
        end
    end

    // pipeline handshake: a stage moves on when the one after it is free
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s_accept;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // scan position inside the glyph
    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [SW-1:0] w_eff, h_eff;
    logic          end_row, last_now;

    assign w_eff    = cagb_pkg::clamp_size(glyph_width_reg);
    assign h_eff    = cagb_pkg::clamp_size(glyph_height_reg);
    // a counter already past a shrunk size counts as on the last column/row
    assign end_row  = ({1'b0, col_reg} + SW'(1)) >= w_eff;
    assign last_now = end_row && (({1'b0, row_reg} + SW'(1)) >= h_eff);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_now)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (end_row)
        begin
            col_next = '0;
            row_next = row_reg + CW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (s_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // destination position and clipping against the framebuffer
    logic signed [XW:0] px, py;
    logic               on_screen;

    assign px = {glyph_left_reg[XW-1], glyph_left_reg} + $signed({{(XW+1-CW){1'b0}}, col_reg});
    assign py = {glyph_top_reg[XW-1], glyph_top_reg} + $signed({{(XW+1-CW){1'b0}}, row_reg});
    assign on_screen = !px[XW] && !py[XW] &&
                       (px[XW-1:0] < screen_width_reg) && (py[XW-1:0] < screen_height_reg);

    // stage 1: position register
    logic [cagb_pkg::ALPHA_W-1:0] s1_cov_reg;
    logic [XW-1:0]                s1_px_reg, s1_py_reg;
    logic                         s1_inside_reg, s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_tready)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_cov_reg    <= s_tdata;
            s1_px_reg     <= px[XW-1:0];
            s1_py_reg     <= py[XW-1:0];
            s1_inside_reg <= on_screen;
            s1_last_reg   <= last_now;
        end
    end

    // stage 2: address multiply and colour blend
    logic [2*XW-1:0]              addr_full;
    logic [cagb_pkg::COLOR_W-1:0] blend_color;

    assign addr_full = (s1_py_reg * screen_width_reg) + {{XW{1'b0}}, s1_px_reg};

    cagb_blend u_blend (
        .alpha   (s1_cov_reg),
        .fore    (fore_color_reg),
        .back    (back_color_reg),
        .blended (blend_color)
    );

    logic                         out_we_reg, out_last_reg;
    logic [cagb_pkg::ADDR_W-1:0]  out_addr_reg;
    logic [cagb_pkg::COLOR_W-1:0] out_color_reg;
    logic                         s1_move;

    assign s1_move = s1_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            out_we_reg    <= s1_inside_reg;
            out_last_reg  <= s1_last_reg;
            out_addr_reg  <= s1_inside_reg ? addr_full[cagb_pkg::ADDR_W-1:0] : '0;
            out_color_reg <= s1_inside_reg ? blend_color : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg, out_addr_reg};
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;

`include "clipped_alpha_glyph_blit_assert.svh"

    `CAGB_ASSERT_NOW(a_clipped_zero, m_tvalid && !m_tuser, m_tdata == '0, "clipped pixel carries data")
    `CAGB_ASSERT_NOW(a_full_stall, s1_valid_reg && m_tvalid && !m_tready, !s_tready, "accepted into full pipeline")
    `CAGB_ASSERT_NEXT(a_last_wrap, s_accept && last_now, col_reg == '0 && row_reg == '0, "scan did not wrap after last pixel")

endmodule

`default_nettype wire
